>>> src/sfcd_pkg.sv
// Shared types, constants and helper functions of the stereo flanger with cubic delay read.
package sfcd_pkg;

   localparam int SAMPLE_BITS         = 24;
   localparam int DELAY_FRACTION_BITS = 8;
   localparam int DELAY_DEPTH         = 2048;
   localparam int LFO_BITS            = 16;

   localparam int DELAY_BITS = 18;
   localparam int FB_BITS    = 16;
   localparam int MIX_BITS   = 17;
   localparam int GAIN_BITS  = 16;
   localparam int MIX_SHIFT  = 16;
   localparam int GAIN_SHIFT = 14;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 18;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_DELAY    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWEEP_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_GAIN = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET_MIX       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTPUT_GAIN   = 3'd4;

   localparam logic [DELAY_BITS-1:0] BASE_DELAY_RESET    = 18'd30720;
   localparam logic [DELAY_BITS-1:0] SWEEP_WIDTH_RESET   = 18'd122880;
   localparam logic [FB_BITS-1:0]    FEEDBACK_GAIN_RESET = 16'd0;
   localparam logic [MIX_BITS-1:0]   WET_MIX_RESET       = 17'd65536;
   localparam logic [GAIN_BITS-1:0]  OUTPUT_GAIN_RESET   = 16'd16384;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
      logic [LFO_BITS-1:0]           lfo_level;
   } req_beat_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_CLAMP,
      ST_POINT,
      ST_READ,
      ST_DRAIN,
      ST_COEF,
      ST_HMUL,
      ST_HADD,
      ST_WET,
      ST_SCALE,
      ST_MIX,
      ST_GAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load_in;
      logic       sweep;
      logic       clamp;
      logic       point;
      logic       rd_en;
      logic [1:0] step;
      logic       coef;
      logic       h_mul;
      logic       h_add;
      logic       wet;
      logic       scale;
      logic       mix;
      logic       gain;
      logic       commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctrl_stat_type;

   // Clamp to the signed sample range.
   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
      lo = -(64'sd1 <<< (SAMPLE_BITS - 1));
      priority if (x > hi) begin
         return hi[SAMPLE_BITS-1:0];
      end else if (x < lo) begin
         return lo[SAMPLE_BITS-1:0];
      end else begin
         return x[SAMPLE_BITS-1:0];
      end
   endfunction

endpackage

>>> src/sfcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfcd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/sfcd_ctrl.sv
// Sequencer that steps one item through delay calculation, store reads and arithmetic.
module sfcd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sfcd_pkg::ctrl_stat_type stat,
   output sfcd_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] READ_LAST   = 2'd3;
   localparam logic [1:0] HORNER_LAST = 2'd2;

   sfcd_pkg::state_type state_ff;
   sfcd_pkg::state_type state_in;
   logic [1:0]          step_ff;
   logic [1:0]          step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfcd_pkg::ST_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sfcd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = sfcd_pkg::ST_SWEEP;
            end
         end
         sfcd_pkg::ST_SWEEP: begin
            cmd.sweep = 1'b1;
            state_in  = sfcd_pkg::ST_CLAMP;
         end
         sfcd_pkg::ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = sfcd_pkg::ST_POINT;
         end
         sfcd_pkg::ST_POINT: begin
            cmd.point = 1'b1;
            step_in   = 2'd0;
            state_in  = sfcd_pkg::ST_READ;
         end
         sfcd_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
            cmd.step  = step_ff;
            if (step_ff == READ_LAST) begin
               step_in  = 2'd0;
               state_in = sfcd_pkg::ST_DRAIN;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         sfcd_pkg::ST_DRAIN: begin
            state_in = sfcd_pkg::ST_COEF;
         end
         sfcd_pkg::ST_COEF: begin
            cmd.coef = 1'b1;
            step_in  = 2'd0;
            state_in = sfcd_pkg::ST_HMUL;
         end
         sfcd_pkg::ST_HMUL: begin
            cmd.h_mul = 1'b1;
            state_in  = sfcd_pkg::ST_HADD;
         end
         sfcd_pkg::ST_HADD: begin
            cmd.h_add = 1'b1;
            cmd.step  = step_ff;
            if (step_ff == HORNER_LAST) begin
               step_in  = 2'd0;
               state_in = sfcd_pkg::ST_WET;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = sfcd_pkg::ST_HMUL;
            end
         end
         sfcd_pkg::ST_WET: begin
            cmd.wet  = 1'b1;
            state_in = sfcd_pkg::ST_SCALE;
         end
         sfcd_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = sfcd_pkg::ST_MIX;
         end
         sfcd_pkg::ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = sfcd_pkg::ST_GAIN;
         end
         sfcd_pkg::ST_GAIN: begin
            cmd.gain = 1'b1;
            state_in = sfcd_pkg::ST_DONE;
         end
         sfcd_pkg::ST_DONE: begin
            // hold until the output register can take the beat
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = sfcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfcd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/sfcd_dpath.sv
// Datapath: settings, delay pointer, delay stores, cubic interpolation and output mixing.
module sfcd_dpath #(
   parameter int DELAY_DEPTH = sfcd_pkg::DELAY_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sfcd_pkg::req_beat_type                req_data,
   input  logic                                  csr_valid,
   input  logic [sfcd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sfcd_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  sfcd_pkg::ctrl_cmd_type                cmd,
   output sfcd_pkg::ctrl_stat_type               stat,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sfcd_pkg::rsp_beat_type                rsp_data
);

   localparam int F   = sfcd_pkg::DELAY_FRACTION_BITS;
   localparam int SB  = sfcd_pkg::SAMPLE_BITS;
   localparam int DB  = sfcd_pkg::DELAY_BITS;
   localparam int LB  = sfcd_pkg::LFO_BITS;
   localparam int AW  = $clog2(DELAY_DEPTH);
   localparam int AW1 = AW + 1;
   localparam int FW  = $clog2(DELAY_DEPTH + 1);
   localparam int PW  = AW + F + 1;
   localparam int DW  = DB + 1;
   localparam int XW  = (PW > DW) ? PW : DW;
   localparam int SPW = DB + LB;

   localparam int CB   = SB + 5;
   localparam int CB1  = CB + 1;
   localparam int HPW  = CB + F + 1;
   localparam int WB   = SB + 4;
   localparam int PMW  = WB + sfcd_pkg::MIX_BITS + 1;
   localparam int PFW  = WB + sfcd_pkg::FB_BITS + 1;
   localparam int MXB  = SB + 6;
   localparam int POW  = MXB + sfcd_pkg::GAIN_BITS + 1;

   localparam logic [XW-1:0]  DMAX      = XW'(longint'(DELAY_DEPTH - 2) << F);
   localparam logic [PW-1:0]  SPAN      = PW'(longint'(DELAY_DEPTH) << F);
   localparam logic [AW-1:0]  LAST_ADDR = AW'(DELAY_DEPTH - 1);
   localparam logic [AW1-1:0] DEPTH_A1  = AW1'(DELAY_DEPTH);
   localparam logic [FW-1:0]  FILL_FULL = FW'(DELAY_DEPTH);

   localparam logic signed [PMW-1:0] PM_HALF =
      PMW'(longint'(1) << (sfcd_pkg::MIX_SHIFT - 1));
   localparam logic signed [PFW-1:0] PF_HALF =
      PFW'(longint'(1) << (sfcd_pkg::MIX_SHIFT - 1));
   localparam logic signed [POW-1:0] PO_HALF =
      POW'(longint'(1) << (sfcd_pkg::GAIN_SHIFT - 1));

   // settings
   logic [DB-1:0]                      base_ff;
   logic [DB-1:0]                      sweep_ff;
   logic [sfcd_pkg::FB_BITS-1:0]       fb_ff;
   logic [sfcd_pkg::MIX_BITS-1:0]      mix_ff;
   logic [sfcd_pkg::GAIN_BITS-1:0]     gain_ff;

   // item state: the dry samples are per channel, the rest is shared by both channels
   logic signed [SB-1:0] dry_ff [2];
   logic [LB-1:0]        lfo_ff;
   logic [SPW-1:0]       prod_ff;
   logic [PW-1:0]        d_ff;
   logic [AW-1:0]        idx_ff;
   logic [F-1:0]         t_ff;
   logic [AW-1:0]        wp_ff;
   logic [FW-1:0]        fill_ff;

   logic                 cap_en_ff;
   logic [1:0]           cap_sel_ff;
   logic                 cap_ok_ff;

   logic                 rsp_valid_ff;
   sfcd_pkg::rsp_beat_type rsp_data_ff;

   logic [DW-1:0]  dsum;
   logic [XW-1:0]  dext;
   logic [PW-1:0]  psum;
   logic [PW-1:0]  pwrap;
   logic [AW-1:0]  addr_lo;
   logic [AW1-1:0] addr_up;
   logic [AW1-1:0] addr_wrap;
   logic [AW-1:0]  rd_addr;
   logic           rd_ok;

   logic signed [SB-1:0] out_val [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= sfcd_pkg::BASE_DELAY_RESET;
         sweep_ff <= sfcd_pkg::SWEEP_WIDTH_RESET;
         fb_ff    <= sfcd_pkg::FEEDBACK_GAIN_RESET;
         mix_ff   <= sfcd_pkg::WET_MIX_RESET;
         gain_ff  <= sfcd_pkg::OUTPUT_GAIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sfcd_pkg::CSR_BASE_DELAY:    base_ff  <= csr_wdata[DB-1:0];
            sfcd_pkg::CSR_SWEEP_WIDTH:   sweep_ff <= csr_wdata[DB-1:0];
            sfcd_pkg::CSR_FEEDBACK_GAIN: fb_ff    <= csr_wdata[sfcd_pkg::FB_BITS-1:0];
            sfcd_pkg::CSR_WET_MIX:       mix_ff   <= csr_wdata[sfcd_pkg::MIX_BITS-1:0];
            sfcd_pkg::CSR_OUTPUT_GAIN:   gain_ff  <= csr_wdata[sfcd_pkg::GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // delay and read position
   always_comb begin
      dsum  = DW'(base_ff) + DW'(prod_ff[SPW-1:LB]);
      dext  = XW'(dsum);
      psum  = PW'({wp_ff, {F{1'b0}}}) + SPAN - d_ff;
      pwrap = (psum >= SPAN) ? (psum - SPAN) : psum;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         dry_ff[0] <= req_data.left_in;
         dry_ff[1] <= req_data.right_in;
         lfo_ff    <= req_data.lfo_level;
      end
      if (cmd.sweep) begin
         prod_ff <= sweep_ff * lfo_ff;
      end
      if (cmd.clamp) begin
         d_ff <= PW'((dext > DMAX) ? DMAX : dext);
      end
      if (cmd.point) begin
         idx_ff <= pwrap[AW+F-1:F];
         t_ff   <= pwrap[F-1:0];
      end
   end

   // neighbour addresses: one behind the read index, then up to two ahead
   always_comb begin
      addr_lo   = (idx_ff == '0) ? LAST_ADDR : (idx_ff - AW'(1));
      addr_up   = AW1'(idx_ff) + AW1'(cmd.step) - AW1'(1);
      addr_wrap = (addr_up >= DEPTH_A1) ? (addr_up - DEPTH_A1) : addr_up;
      rd_addr   = (cmd.step == 2'd0) ? addr_lo : addr_wrap[AW-1:0];
      // entries past the fill count were never written and read as zero
      rd_ok     = AW1'(rd_addr) < AW1'(fill_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_en_ff <= 1'b0;
      end else begin
         cap_en_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      cap_sel_ff <= cmd.step;
      cap_ok_ff  <= rd_ok;
   end

   // write pointer and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (cmd.commit) begin
         wp_ff <= (wp_ff == LAST_ADDR) ? '0 : (wp_ff + AW'(1));
         if (fill_ff != FILL_FULL) begin
            fill_ff <= fill_ff + FW'(1);
         end
      end
   end

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [SB-1:0]         rd_data;
      logic signed [SB-1:0]  s_ff [4];
      logic signed [CB-1:0]  se0;
      logic signed [CB-1:0]  se1;
      logic signed [CB-1:0]  se2;
      logic signed [CB-1:0]  se3;
      logic signed [CB-1:0]  v_ff;
      logic signed [CB-1:0]  c1_ff;
      logic signed [CB-1:0]  c2_ff;
      logic signed [CB-1:0]  c3_ff;
      logic signed [CB-1:0]  c_next;
      logic signed [HPW-1:0] hp_ff;
      logic signed [HPW-1:0] hp_sh;
      logic signed [CB1-1:0] v_inc;
      logic signed [WB-1:0]  wet_ff;
      logic signed [PMW-1:0] pm_ff;
      logic signed [PFW-1:0] pf_ff;
      logic signed [PMW-1:0] pm_rnd;
      logic signed [PFW-1:0] pf_rnd;
      logic signed [MXB-1:0] mixed_ff;
      logic signed [SB-1:0]  fbv_ff;
      logic signed [POW-1:0] po_ff;
      logic signed [POW-1:0] po_rnd;

      sfcd_ram #(
         .WIDTH (SB),
         .DEPTH (DELAY_DEPTH)
      ) u_store (
         .clock   (clock),
         .wr_en   (cmd.commit),
         .wr_addr (wp_ff),
         .wr_data (fbv_ff),
         .rd_en   (cmd.rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_data)
      );

      always_comb begin
         se0   = CB'(s_ff[0]);
         se1   = CB'(s_ff[1]);
         se2   = CB'(s_ff[2]);
         se3   = CB'(s_ff[3]);
         case (cmd.step)
            2'd0:    c_next = c1_ff;
            2'd1:    c_next = c2_ff;
            default: c_next = c3_ff;
         endcase
         hp_sh  = hp_ff >>> F;
         v_inc  = CB1'(v_ff) + CB1'(1);
         pm_rnd = (pm_ff + PM_HALF) >>> sfcd_pkg::MIX_SHIFT;
         pf_rnd = (pf_ff + PF_HALF) >>> sfcd_pkg::MIX_SHIFT;
         po_rnd = (po_ff + PO_HALF) >>> sfcd_pkg::GAIN_SHIFT;
      end

      always_ff @(posedge clock) begin
         if (cap_en_ff) begin
            s_ff[cap_sel_ff] <= cap_ok_ff ? rd_data : '0;
         end
         // doubled Catmull-Rom coefficients
         if (cmd.coef) begin
            v_ff  <= (se1 <<< 1) + se1 - ((se2 <<< 1) + se2) + se3 - se0;
            c1_ff <= (se0 <<< 1) - ((se1 <<< 2) + se1) + (se2 <<< 2) - se3;
            c2_ff <= se2 - se0;
            c3_ff <= se1 <<< 1;
         end
         if (cmd.h_mul) begin
            hp_ff <= v_ff * $signed({1'b0, t_ff});
         end
         if (cmd.h_add) begin
            v_ff <= CB'(hp_sh) + c_next;
         end
         if (cmd.wet) begin
            wet_ff <= WB'(v_inc >>> 1);
         end
         if (cmd.scale) begin
            pm_ff <= wet_ff * $signed({1'b0, mix_ff});
            pf_ff <= wet_ff * $signed({1'b0, fb_ff});
         end
         if (cmd.mix) begin
            mixed_ff <= MXB'(dry_ff[ln]) + MXB'(pm_rnd);
            fbv_ff   <= sfcd_pkg::sat_sample(64'(dry_ff[ln]) + 64'(pf_rnd));
         end
         if (cmd.gain) begin
            po_ff <= mixed_ff * $signed({1'b0, gain_ff});
         end
      end

      assign out_val[ln] = sfcd_pkg::sat_sample(64'(po_rnd));
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff.left_out  <= out_val[0];
         rsp_data_ff.right_out <= out_val[1];
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

>>> src/stereo_flanger_cubic_delay_top.sv
// Top level of the stereo flanger with modulated delay and cubic interpolation.
//
// Request channel (req_valid / req_stall / req_data): one beat carries a stereo
// sample pair and the LFO level. A beat is taken when req_valid is high and
// req_stall is low. Response channel (rsp_valid / rsp_stall / rsp_data): one
// beat with the stereo output per request beat, in order. Settings port
// (csr_valid / csr_ready / csr_index / csr_wdata): csr_ready is always high;
// write settings only while no item is in flight.
//
// One item is worked at a time: the request side stays stalled from the
// taken request until the item's response beat is committed. The work of
// an item is the four neighbour reads per channel through the single read port
// of each delay store, followed by three Horner multiply/add rounds and the
// mix and gain multiplies.
//
// A finished beat waits in the output register while the next request is
// taken and worked; if rsp_stall still holds the old beat when the new one is
// done, the block holds it and keeps req_stall high until the old beat drains.
// Reset (synchronous) restores the settings, zeroes the write pointer and the
// fill count: store entries not yet written since reset read as zero.
module stereo_flanger_cubic_delay_top #(
   parameter int DELAY_DEPTH = sfcd_pkg::DELAY_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sfcd_pkg::req_beat_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sfcd_pkg::rsp_beat_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sfcd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sfcd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   sfcd_pkg::ctrl_cmd_type  cmd;
   sfcd_pkg::ctrl_stat_type stat;

   // settings are registered directly, never backpressured
   assign csr_ready = 1'b1;

   // sequencer: owns the request handshake and steps the datapath
   sfcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: settings, delay stores, interpolation, output register
   sfcd_dpath #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> src/sfcd_checker.sv
// Port-level checks for the flanger top level and the bind that attaches them.
module sfcd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sfcd_pkg::rsp_beat_type rsp_data
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // one item at a time: a taken request closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in flight");

   // reset leaves no response pending and the request side open
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("bad state after reset");

   // a new response beat only comes out of work in progress
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response beat without an item in flight");

endmodule

bind stereo_flanger_cubic_delay_top sfcd_checker u_sfcd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/stereo_flanger_cubic_delay_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stereo flanger with modulated cubic delay read.
module stereo_flanger_cubic_delay_top_tb;
   import sfcd_pkg::*;

   // Run control: the slowest legal run (every beat waiting out the longest
   // sender gap and receiver stall on top of the item time) stays well under
   // a quarter of the cycle limit.
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 165;

   localparam longint DELAY_SPAN = longint'(DELAY_DEPTH) << DELAY_FRACTION_BITS;
   localparam longint DELAY_CAP  = longint'(DELAY_DEPTH - 2) << DELAY_FRACTION_BITS;

   // Top of each register's documented range.
   localparam int BASE_DELAY_TOP    = 262143;
   localparam int SWEEP_WIDTH_TOP   = 262143;
   localparam int FEEDBACK_GAIN_TOP = 32768;
   localparam int WET_MIX_TOP       = 65536;
   localparam int OUTPUT_GAIN_TOP   = 32768;
   // Usual delay ranges keep most reads inside already written history.
   localparam int BASE_DELAY_USUAL  = 64 << DELAY_FRACTION_BITS;
   localparam int SWEEP_WIDTH_USUAL = 256 << DELAY_FRACTION_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP_INDEX = '1;
   localparam logic [CSR_DATA_BITS-1:0]  WDATA_ONES    = '1;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG_ONE = '1;

   typedef enum {STALL_OFF, STALL_FLICKER, STALL_LONG, STALL_PATTERN} stall_kind_e;
   typedef enum {SET_RANDOM, SET_ZERO, SET_SPEC_TOP, SET_ALL_ONES} setting_style_e;

   // Tracks the flanger's settings, both delay lines and the write pointer,
   // and queues the output pair each accepted input beat must produce.
   class flanger_tracker;
      logic [DELAY_BITS-1:0]         base_delay;
      logic [DELAY_BITS-1:0]         sweep_width;
      logic [FB_BITS-1:0]            feedback_gain;
      logic [MIX_BITS-1:0]           wet_mix;
      logic [GAIN_BITS-1:0]          output_gain;
      logic signed [SAMPLE_BITS-1:0] line [2][DELAY_DEPTH];
      int unsigned                   wr_ptr;
      rsp_beat_type                  due_outputs[$];
      int                            errors;
      int                            taken;
      int                            compared;
      int                            clamped;

      function new();
         base_delay    = BASE_DELAY_RESET;
         sweep_width   = SWEEP_WIDTH_RESET;
         feedback_gain = FEEDBACK_GAIN_RESET;
         wet_mix       = WET_MIX_RESET;
         output_gain   = OUTPUT_GAIN_RESET;
         foreach (line[c, i]) line[c][i] = '0;
         wr_ptr   = 0;
         errors   = 0;
         taken    = 0;
         compared = 0;
         clamped  = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_BASE_DELAY:    base_delay    = data[DELAY_BITS-1:0];
            CSR_SWEEP_WIDTH:   sweep_width   = data[DELAY_BITS-1:0];
            CSR_FEEDBACK_GAIN: feedback_gain = data[FB_BITS-1:0];
            CSR_WET_MIX:       wet_mix       = data[MIX_BITS-1:0];
            CSR_OUTPUT_GAIN:   output_gain   = data[GAIN_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [SAMPLE_BITS-1:0] clip(longint x);
         longint top;
         top = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
         if (x > top) x = top;
         else if (x < -top - 1) x = -top - 1;
         return x[SAMPLE_BITS-1:0];
      endfunction

      // Interpolate one channel, write its feedback sample, return its output.
      function logic signed [SAMPLE_BITS-1:0] run_channel(int ch, int unsigned tap,
                                                          longint frac, longint dry);
         longint s0, s1, s2, s3;
         longint c0, c1, c2, c3;
         longint acc, wet, mixed;
         s0 = line[ch][(tap + DELAY_DEPTH - 1) % DELAY_DEPTH];
         s1 = line[ch][tap % DELAY_DEPTH];
         s2 = line[ch][(tap + 1) % DELAY_DEPTH];
         s3 = line[ch][(tap + 2) % DELAY_DEPTH];
         c0 = -s0 + 3 * s1 - 3 * s2 + s3;
         c1 = 2 * s0 - 5 * s1 + 4 * s2 - s3;
         c2 = s2 - s0;
         c3 = 2 * s1;
         acc = c0;
         acc = ((acc * frac) >>> DELAY_FRACTION_BITS) + c1;
         acc = ((acc * frac) >>> DELAY_FRACTION_BITS) + c2;
         acc = ((acc * frac) >>> DELAY_FRACTION_BITS) + c3;
         wet = (acc + 1) >>> 1;
         mixed = dry + ((wet * longint'(wet_mix) + (longint'(1) <<< (MIX_SHIFT - 1)))
                        >>> MIX_SHIFT);
         line[ch][wr_ptr] = clip(dry + ((wet * longint'(feedback_gain)
                                         + (longint'(1) <<< (MIX_SHIFT - 1))) >>> MIX_SHIFT));
         return clip((mixed * longint'(output_gain) + (longint'(1) <<< (GAIN_SHIFT - 1)))
                     >>> GAIN_SHIFT);
      endfunction

      function void take_input(req_beat_type beat);
         longint       reach;
         longint       pos;
         int unsigned  tap;
         longint       frac;
         rsp_beat_type want;
         reach = longint'(base_delay)
                 + ((longint'(sweep_width) * longint'(beat.lfo_level)) >>> LFO_BITS);
         if (reach > DELAY_CAP) begin
            reach = DELAY_CAP;
            clamped++;
         end
         pos  = ((longint'(wr_ptr) << DELAY_FRACTION_BITS) + DELAY_SPAN - reach) % DELAY_SPAN;
         tap  = int'(pos >>> DELAY_FRACTION_BITS);
         frac = pos & ((longint'(1) << DELAY_FRACTION_BITS) - 1);
         want.left_out  = run_channel(0, tap, frac, longint'(beat.left_in));
         want.right_out = run_channel(1, tap, frac, longint'(beat.right_in));
         wr_ptr = (wr_ptr + 1) % DELAY_DEPTH;
         due_outputs.push_back(want);
         taken++;
      endfunction

      function void match_output(rsp_beat_type got);
         rsp_beat_type want;
         if (due_outputs.size() == 0) begin
            $error("output beat with nothing expected: left_out %0d right_out %0d",
                   got.left_out, got.right_out);
            errors++;
            return;
         end
         want = due_outputs.pop_front();
         compared++;
         if (got.left_out !== want.left_out) begin
            $error("left_out mismatch: expected %0d, actual %0d", want.left_out, got.left_out);
            errors++;
         end
         if (got.right_out !== want.right_out) begin
            $error("right_out mismatch: expected %0d, actual %0d", want.right_out, got.right_out);
            errors++;
         end
      endfunction
   endclass

   // All block inputs start at known values.
   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_beat_type              req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_beat_type              rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_BASE_DELAY;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   flanger_tracker tracker = new();

   // Receiver stall control, set per phase by the stimulus process.
   stall_kind_e stall_mode = STALL_OFF;
   logic [15:0] stall_mask = '0;
   int          stall_run  = 0;
   int          stall_tick = 0;
   int          cycle_count = 0;

   // Last driven values, so ramps continue smoothly from beat to beat.
   logic [SAMPLE_BITS-1:0] prev_left  = '0;
   logic [SAMPLE_BITS-1:0] prev_right = '0;
   logic [LFO_BITS-1:0]    prev_lfo   = '0;

   stereo_flanger_cubic_delay_top dut (.*);

   always #5 clock = ~clock;

   // Bound the run: a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Drive rsp_stall: hold each level for a random run, or walk a fixed mask.
   always @(posedge clock) begin
      if (reset || stall_mode == STALL_OFF) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else begin
         case (stall_mode)
            STALL_FLICKER: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
               stall_run <= $urandom_range(0, 2);
            end
            STALL_LONG: begin
               rsp_stall <= !rsp_stall;
               stall_run <= rsp_stall ? $urandom_range(0, 20) : $urandom_range(0, 60);
            end
            default: begin
               rsp_stall  <= stall_mask[stall_tick % 16];
               stall_tick <= stall_tick + 1;
            end
         endcase
      end
   end

   // Sample the output channel mid-cycle, where everything has settled; a beat
   // seen valid and unstalled here is taken at the next rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         tracker.match_output(rsp_data);
      end
   end

   // Present one input beat and hold it until the block takes it. Leave
   // req_valid high so a burst continues without a dead cycle.
   task automatic send(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                       logic [LFO_BITS-1:0] lfo);
      req_beat_type beat;
      beat.left_in   = l;
      beat.right_in  = r;
      beat.lfo_level = lfo;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(negedge clock);
      while (req_stall !== 1'b0) @(negedge clock);
      @(posedge clock);
      tracker.take_input(beat);
      prev_left  = l;
      prev_right = r;
      prev_lfo   = lfo;
   endtask

   // Write one register; the block must be idle.
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      while (csr_ready !== 1'b1) @(negedge clock);
      @(posedge clock);
      tracker.set_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Advance at least one edge, then until every queued output has drained.
   task automatic wait_drained();
      do @(posedge clock); while (tracker.due_outputs.size() != 0);
   endtask

   // Stop sending and let the block empty out.
   task automatic close_phase();
      req_valid <= 1'b0;
      wait_drained();
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_setting(setting_style_e style,
                                                             int spec_hi, int usual_hi);
      case (style)
         SET_ZERO:     return '0;
         SET_SPEC_TOP: return CSR_DATA_BITS'(spec_hi);
         SET_ALL_ONES: return WDATA_ONES;
         default: begin
            case ($urandom_range(0, 6))
               0:       return '0;
               1:       return CSR_DATA_BITS'(spec_hi);
               2:       return CSR_DATA_BITS'($urandom());
               3:       return CSR_DATA_BITS'($urandom_range(0, spec_hi));
               default: return CSR_DATA_BITS'($urandom_range(0, usual_hi));
            endcase
         end
      endcase
   endfunction

   task automatic load_settings(setting_style_e style);
      write_csr(CSR_BASE_DELAY,    pick_setting(style, BASE_DELAY_TOP, BASE_DELAY_USUAL));
      write_csr(CSR_SWEEP_WIDTH,   pick_setting(style, SWEEP_WIDTH_TOP, SWEEP_WIDTH_USUAL));
      write_csr(CSR_FEEDBACK_GAIN, pick_setting(style, FEEDBACK_GAIN_TOP, FEEDBACK_GAIN_TOP));
      write_csr(CSR_WET_MIX,       pick_setting(style, WET_MIX_TOP, WET_MIX_TOP));
      write_csr(CSR_OUTPUT_GAIN,   pick_setting(style, OUTPUT_GAIN_TOP, OUTPUT_GAIN_TOP));
      // Unmapped indexes must leave every setting alone.
      if ($urandom_range(0, 2) == 0) write_csr(CSR_TOP_INDEX, CSR_DATA_BITS'($urandom()));
   endtask

   // Mix of full-range noise, rail values, small signals and random-walk ramps.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [SAMPLE_BITS-1:0] prev);
      int offset;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return SAMPLE_BITS'($urandom());
         4:          return $urandom_range(0, 1) ? SAMPLE_HI : SAMPLE_LO;
         5, 6: begin
            offset = int'($urandom_range(0, 8191)) - 4096;
            return SAMPLE_BITS'(offset);
         end
         default: begin
            offset = int'($urandom_range(0, 131072)) - 65536;
            return prev + SAMPLE_BITS'(offset);
         end
      endcase
   endfunction

   function automatic logic [LFO_BITS-1:0] pick_lfo(logic [LFO_BITS-1:0] prev);
      case ($urandom_range(0, 9))
         5, 6:    return prev + LFO_BITS'($urandom_range(0, 511));
         7:       return '0;
         8:       return '1;
         default: return LFO_BITS'($urandom());
      endcase
   endfunction

   initial begin : stimulus
      setting_style_e style;
      int             max_gap;
      int             gap;
      int             burst_left;
      int             pause_at;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, empty delay lines: output is the dry signal at unity.
      send(SAMPLE_HI, SAMPLE_LO, '0);
      send(SAMPLE_LO, SAMPLE_HI, '1);
      send('0, '0, 16'h8000);
      send(SAMPLE_BITS'(1), SAMPLE_NEG_ONE, LFO_BITS'(1));
      close_phase();

      // Zero delay: the taps straddle the write pointer, so the newest and
      // oldest stored samples meet in one interpolation window.
      write_csr(CSR_BASE_DELAY, '0);
      write_csr(CSR_SWEEP_WIDTH, '0);
      write_csr(CSR_FEEDBACK_GAIN, CSR_DATA_BITS'(FEEDBACK_GAIN_TOP));
      write_csr(CSR_WET_MIX, CSR_DATA_BITS'(WET_MIX_TOP));
      write_csr(CSR_OUTPUT_GAIN, CSR_DATA_BITS'(OUTPUT_GAIN_RESET));
      for (int i = 0; i < 6; i++) begin
         send(i[0] ? SAMPLE_LO : SAMPLE_HI, i[0] ? SAMPLE_HI : SAMPLE_LO, i[1] ? '1 : '0);
      end
      close_phase();

      // Two and a half samples of delay over rail-to-rail input with every gain
      // past its range: the cubic overshoots and both paths saturate.
      write_csr(CSR_BASE_DELAY, CSR_DATA_BITS'((2 << DELAY_FRACTION_BITS)
                                               + (1 << (DELAY_FRACTION_BITS - 1))));
      write_csr(CSR_SWEEP_WIDTH, WDATA_ONES);
      write_csr(CSR_FEEDBACK_GAIN, WDATA_ONES);
      write_csr(CSR_WET_MIX, WDATA_ONES);
      write_csr(CSR_OUTPUT_GAIN, WDATA_ONES);
      for (int i = 0; i < 8; i++) begin
         send(i[0] ? SAMPLE_LO : SAMPLE_HI, i[0] ? SAMPLE_HI : SAMPLE_LO, (i >= 6) ? '1 : '0);
      end
      close_phase();

      // Longest settings: a full LFO pushes the delay into its clamp. Write
      // every unmapped index first; none may disturb the settings.
      for (int i = CSR_OUTPUT_GAIN + 1; i <= CSR_TOP_INDEX; i++) begin
         write_csr(CSR_INDEX_BITS'(i), WDATA_ONES);
      end
      write_csr(CSR_BASE_DELAY, CSR_DATA_BITS'(BASE_DELAY_TOP));
      write_csr(CSR_SWEEP_WIDTH, CSR_DATA_BITS'(SWEEP_WIDTH_TOP));
      write_csr(CSR_FEEDBACK_GAIN, '0);
      write_csr(CSR_WET_MIX, CSR_DATA_BITS'(WET_MIX_TOP));
      write_csr(CSR_OUTPUT_GAIN, CSR_DATA_BITS'(OUTPUT_GAIN_TOP));
      send(SAMPLE_HI, SAMPLE_LO, '1);
      send(SAMPLE_LO, SAMPLE_HI, '1);
      send(SAMPLE_BITS'(100), SAMPLE_NEG_ONE, 16'hFF80);
      send('0, '0, '0);
      close_phase();

      // Random phases: new settings each time, first phase without any idling,
      // the next three on the zero, documented-top and all-ones extremes.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            1:       style = SET_ZERO;
            2:       style = SET_SPEC_TOP;
            3:       style = SET_ALL_ONES;
            default: style = SET_RANDOM;
         endcase
         load_settings(style);
         if (ph == 0) begin
            max_gap    = 0;
            stall_mode = STALL_OFF;
         end else begin
            case ($urandom_range(0, 3))
               0:       max_gap = 0;
               1:       max_gap = 8;
               2:       max_gap = 25;
               default: max_gap = 45;
            endcase
            stall_mask = 16'($urandom());
            stall_mode = stall_kind_e'($urandom_range(0, 3));
         end
         pause_at   = $urandom_range(10, PHASE_ITEMS - 10);
         burst_left = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            gap = 0;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               if (max_gap != 0) gap = $urandom_range(0, max_gap);
            end
            // Drop valid for the gap; once per phase also hold off until the
            // block has handed back every pending output.
            if (gap != 0 || n == pause_at) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
               if (n == pause_at) wait_drained();
            end
            send(pick_sample(prev_left), pick_sample(prev_right), pick_lfo(prev_lfo));
            burst_left--;
         end
         close_phase();
      end

      stall_mode = STALL_OFF;
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d input beats, %0d output beats compared, %0d settings phases",
               tracker.taken, tracker.compared, RANDOM_PHASES + 4);
      $display("summary: delay clamp hit on %0d beats; gaps, holds and stall patterns varied",
               tracker.clamped);
      if (tracker.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
